@@ src/vupt_pkg.sv @@
// shared types and constants for the video unit register port and timing block
// no dependencies; imported by vupt_core, vupt_out and the top level
`default_nettype none

package vupt_pkg;

    // request kinds carried in the func field
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // register indexes that have an effect
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    // which store the data port reaches
    localparam logic [1:0] TGT_PAT = 2'd0;
    localparam logic [1:0] TGT_NT  = 2'd1;
    localparam logic [1:0] TGT_PAL = 2'd2;

    // what the result stage has to build
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam int PAT_DEPTH = 8192;
    localparam int NT_DEPTH  = 2048;
    localparam int PAL_DEPTH = 32;
    localparam int PAT_AW    = 13;
    localparam int NT_AW     = 11;
    localparam int PAL_AW    = 5;

    localparam logic [8:0] DOTS_PER_LINE  = 9'd341;
    localparam logic [8:0] VISIBLE_LINES  = 9'd240;
    localparam logic [8:0] VBLANK_LINE    = 9'd241;
    localparam logic [8:0] PRERENDER_LINE = 9'd261;
    localparam logic [8:0] LAST_FETCH_DOT = 9'd256;

    // status bits other than vblank never change from their reset value
    localparam logic [6:0] STATUS_LOW = 7'h20;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [1:0] tgt;
        logic       vblank_old;
        logic       nmi;
        logic       vblank;
    } t_stage;

    typedef struct packed {
        logic                we_pat;
        logic                we_nt;
        logic                we_pal;
        logic                re;
        logic [PAT_AW-1:0]   a_pat;
        logic [NT_AW-1:0]    a_nt;
        logic [PAL_AW-1:0]   a_pal;
        logic [7:0]          wdata;
    } t_mem_cmd;

endpackage

`default_nettype wire

@@ src/vupt_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module vupt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/vupt_core.sv @@
// register port, address logic, dot timing and store clearing pass
// uses vupt_pkg; drives the ram commands and the first result stage
`default_nettype none

module vupt_core
    import vupt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [2:0]  i_reg_index,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_s1_take,
    output t_stage           o_s1,
    output t_mem_cmd         o_mem
);

    logic        r_ctrl_nmi, n_ctrl_nmi;
    logic        r_ctrl_inc, n_ctrl_inc;
    logic        r_vblank, n_vblank;
    logic [14:0] r_cur, n_cur;
    logic [14:0] r_tmp, n_tmp;
    logic        r_toggle, n_toggle;
    logic [8:0]  r_dot, n_dot;
    logic [8:0]  r_line, n_line;
    logic        r_nmi, n_nmi;
    logic        r_mirror;
    logic        r_clearing, n_clearing;
    logic [PAT_AW-1:0] r_clr_cnt, n_clr_cnt;
    t_stage      r_s1, n_s1;

    logic        acc;
    logic [8:0]  dot_inc;
    logic        visible;
    logic        do_cx;
    logic        do_y;
    logic [14:0] cur_x;
    logic [14:0] cur_adv;
    logic [13:0] port_a;
    logic [1:0]  port_tgt;

    function automatic logic [14:0] f_coarse_x(input logic [14:0] a);
        logic [14:0] r;
        r = a;
        if (a[4:0] == 5'd31) begin
            r[4:0] = 5'd0;
            r[10]  = ~a[10];
        end else begin
            r[4:0] = a[4:0] + 5'd1;
        end
        return r;
    endfunction

    function automatic logic [14:0] f_incr_y(input logic [14:0] a);
        logic [14:0] r;
        logic [4:0]  y;
        r = a;
        y = a[9:5];
        if (a[14:12] != 3'd7) begin
            r[14:12] = a[14:12] + 3'd1;
        end else begin
            r[14:12] = 3'd0;
            if (y == 5'd29) begin
                y     = 5'd0;
                r[11] = ~a[11];
            end else if (y == 5'd31) begin
                y = 5'd0;
            end else begin
                y = y + 5'd1;
            end
            r[9:5] = y;
        end
        return r;
    endfunction

    // horizontal pairs tables 0,1 and 2,3; vertical pairs 0,2 and 1,3
    function automatic logic [NT_AW-1:0] f_nt_index(input logic [13:0] a, input logic mirror);
        logic tbl;
        tbl = mirror ? a[10] : a[11];
        return {tbl, a[9:0]};
    endfunction

    // backdrop entries of the sprite palettes alias the background ones
    function automatic logic [PAL_AW-1:0] f_pal_index(input logic [13:0] a);
        logic [PAL_AW-1:0] p;
        p = a[4:0];
        if (p[4] && (p[1:0] == 2'd0)) begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

    assign o_ready = !r_clearing && (!r_s1.valid || i_s1_take);
    assign acc     = i_valid && o_ready;
    assign o_s1    = r_s1;

    assign dot_inc = r_dot + 9'd1;
    assign visible = r_line < VISIBLE_LINES;
    assign do_cx   = visible && (dot_inc[2:0] == 3'd0) && (dot_inc <= LAST_FETCH_DOT);
    assign do_y    = visible && (dot_inc == LAST_FETCH_DOT);
    assign cur_x   = do_cx ? f_coarse_x(r_cur) : r_cur;
    assign cur_adv = r_cur + (r_ctrl_inc ? 15'd32 : 15'd1);

    assign port_a  = r_cur[13:0];
    always_comb begin
        if (!port_a[13]) begin
            port_tgt = TGT_PAT;
        end else if (port_a[13:8] != 6'h3F) begin
            port_tgt = TGT_NT;
        end else begin
            port_tgt = TGT_PAL;
        end
    end

    always_comb begin
        n_ctrl_nmi = r_ctrl_nmi;
        n_ctrl_inc = r_ctrl_inc;
        n_vblank   = r_vblank;
        n_cur      = r_cur;
        n_tmp      = r_tmp;
        n_toggle   = r_toggle;
        n_dot      = r_dot;
        n_line     = r_line;
        n_nmi      = r_nmi;
        n_clearing = r_clearing;
        n_clr_cnt  = r_clr_cnt;
        n_s1       = r_s1;

        o_mem.we_pat = 1'b0;
        o_mem.we_nt  = 1'b0;
        o_mem.we_pal = 1'b0;
        o_mem.re     = 1'b0;
        o_mem.a_pat  = port_a[PAT_AW-1:0];
        o_mem.a_nt   = f_nt_index(port_a, r_mirror);
        o_mem.a_pal  = f_pal_index(port_a);
        o_mem.wdata  = i_write_data;

        if (i_s1_take) begin
            n_s1.valid = 1'b0;
        end

        // zero all three stores, one address a cycle, before taking requests
        if (r_clearing) begin
            o_mem.we_pat = 1'b1;
            o_mem.we_nt  = 1'b1;
            o_mem.we_pal = 1'b1;
            o_mem.a_pat  = r_clr_cnt;
            o_mem.a_nt   = r_clr_cnt[NT_AW-1:0];
            o_mem.a_pal  = r_clr_cnt[PAL_AW-1:0];
            o_mem.wdata  = 8'd0;
            n_clr_cnt    = r_clr_cnt + 1'b1;
            if (r_clr_cnt == {PAT_AW{1'b1}}) begin
                n_clearing = 1'b0;
            end
        end

        if (acc) begin
            n_s1.valid      = 1'b1;
            n_s1.kind       = KIND_NONE;
            n_s1.tgt        = port_tgt;
            n_s1.vblank_old = r_vblank;

            unique case (i_func)
                FUNC_WRITE: begin
                    unique case (i_reg_index)
                        REG_CTRL: begin
                            n_ctrl_nmi    = i_write_data[7];
                            n_ctrl_inc    = i_write_data[2];
                            n_tmp[11:10]  = i_write_data[1:0];
                        end
                        REG_SCROLL: begin
                            if (!r_toggle) begin
                                n_tmp[4:0] = i_write_data[7:3];
                            end else begin
                                n_tmp[14:12] = i_write_data[2:0];
                                n_tmp[9:5]   = i_write_data[7:3];
                            end
                            n_toggle = !r_toggle;
                        end
                        REG_ADDR: begin
                            if (!r_toggle) begin
                                n_tmp[14]   = 1'b0;
                                n_tmp[13:8] = i_write_data[5:0];
                            end else begin
                                n_tmp[7:0] = i_write_data;
                                n_cur      = {r_tmp[14:8], i_write_data};
                            end
                            n_toggle = !r_toggle;
                        end
                        REG_DATA: begin
                            o_mem.we_pat = (port_tgt == TGT_PAT);
                            o_mem.we_nt  = (port_tgt == TGT_NT);
                            o_mem.we_pal = (port_tgt == TGT_PAL);
                            n_cur        = cur_adv;
                        end
                        default: begin
                        end
                    endcase
                end
                FUNC_READ: begin
                    if (i_reg_index == REG_STATUS) begin
                        n_s1.kind = KIND_STATUS;
                        n_vblank  = 1'b0;
                        n_toggle  = 1'b0;
                        n_nmi     = 1'b0;
                    end else if (i_reg_index == REG_DATA) begin
                        n_s1.kind = KIND_DATA;
                        o_mem.re  = 1'b1;
                        n_cur     = cur_adv;
                    end
                end
                FUNC_TICK: begin
                    n_cur = do_y ? f_incr_y(cur_x) : cur_x;
                    n_nmi = 1'b0;
                    if ((r_line == VBLANK_LINE) && (dot_inc == 9'd1)) begin
                        n_vblank = 1'b1;
                        n_nmi    = r_ctrl_nmi;
                    end
                    if ((r_line == PRERENDER_LINE) && (dot_inc == 9'd1)) begin
                        n_vblank = 1'b0;
                    end
                    if (dot_inc >= DOTS_PER_LINE) begin
                        n_dot  = 9'd0;
                        n_line = (r_line == PRERENDER_LINE) ? 9'd0 : r_line + 9'd1;
                    end else begin
                        n_dot = dot_inc;
                    end
                end
                default: begin
                end
            endcase

            n_s1.nmi    = n_nmi;
            n_s1.vblank = n_vblank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_nmi <= 1'b0;
            r_ctrl_inc <= 1'b0;
            r_vblank   <= 1'b1;
            r_cur      <= '0;
            r_tmp      <= '0;
            r_toggle   <= 1'b0;
            r_dot      <= '0;
            r_line     <= '0;
            r_nmi      <= 1'b0;
            r_mirror   <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_s1       <= '0;
        end else begin
            r_ctrl_nmi <= n_ctrl_nmi;
            r_ctrl_inc <= n_ctrl_inc;
            r_vblank   <= n_vblank;
            r_cur      <= n_cur;
            r_tmp      <= n_tmp;
            r_toggle   <= n_toggle;
            r_dot      <= n_dot;
            r_line     <= n_line;
            r_nmi      <= n_nmi;
            r_clearing <= n_clearing;
            r_clr_cnt  <= n_clr_cnt;
            r_s1       <= n_s1;
            if (i_cfg_we) begin
                r_mirror <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/vupt_out.sv @@
// result stage: read buffer and the output register of the result channel
// uses vupt_pkg; takes the first stage from vupt_core and the ram read data
`default_nettype none

module vupt_out
    import vupt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_stage     i_s1,
    input  wire logic [7:0] i_pat_q,
    input  wire logic [7:0] i_nt_q,
    input  wire logic [7:0] i_pal_q,
    input  wire logic       i_ready,
    output logic            o_take,
    output logic            o_valid,
    output logic [7:0]      o_read_data,
    output logic            o_nmi,
    output logic            o_vblank
);

    logic       r_valid, n_valid;
    logic [7:0] r_data, n_data;
    logic       r_nmi, n_nmi;
    logic       r_vb, n_vb;
    logic [7:0] r_rbuf, n_rbuf;
    logic [7:0] mem_q;

    assign o_take = i_s1.valid && (!r_valid || i_ready);

    always_comb begin
        unique case (i_s1.tgt)
            TGT_PAT: mem_q = i_pat_q;
            TGT_NT:  mem_q = i_nt_q;
            default: mem_q = i_pal_q;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_nmi   = r_nmi;
        n_vb    = r_vb;
        n_rbuf  = r_rbuf;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (o_take) begin
            n_valid = 1'b1;
            n_nmi   = i_s1.nmi;
            n_vb    = i_s1.vblank;
            unique case (i_s1.kind)
                KIND_STATUS: n_data = {i_s1.vblank_old, STATUS_LOW};
                KIND_DATA: begin
                    // palette reads bypass the buffer, the rest return the old buffer
                    n_data = (i_s1.tgt == TGT_PAL) ? mem_q : r_rbuf;
                    n_rbuf = mem_q;
                end
                default: n_data = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rbuf  <= 8'd0;
        end else begin
            r_valid <= n_valid;
            r_rbuf  <= n_rbuf;
        end
        r_data <= n_data;
        r_nmi  <= n_nmi;
        r_vb   <= n_vb;
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_data;
    assign o_nmi       = r_nmi;
    assign o_vblank    = r_vb;

endmodule

`default_nettype wire

@@ src/video_unit_register_port_and_timing.sv @@
// top level of the video unit register port and dot timing block
// depends on vupt_pkg, vupt_ram, vupt_core and vupt_out
//
// usage:
//   request channel s_axis: each request is a register write, a register
//   read or one dot tick. one request can be taken every clock while s_axis_tready is high.
//   result channel m_axis: exactly one result per request, in order, with the
//   read byte, the nmi request and the vblank bit as they stand after it.
//   pipeline: first stage, then the result register that drives m_axis.
//   throughput: one request per cycle when not stalled; pattern, nametable
//   and palette stores sit in rams with registered reads, read at the current
//   address as the request is taken; the read buffer is updated in the result stage.
//   stall: the result register plus the first stage hold two requests; once
//   both are full s_axis_tready drops until m_axis_tready is seen.
//   reset: synchronous, active low. afterwards a clearing pass zeroes every
//   address of the stores with s_axis_tready low; mirroring writes on
//   i_cfg_we are taken at any time, but are meant to land while idle.
`default_nettype none

module video_unit_register_port_and_timing
    import vupt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [2:0] reg_index, [10:3] write_data
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [7:0] read_data, [8] nmi_request, [9] vblank
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata    // mirroring: 0 horizontal, 1 vertical
);

    t_stage     s1;
    t_mem_cmd   mem;
    logic       s1_take;
    logic [7:0] pat_q;
    logic [7:0] nt_q;
    logic [7:0] pal_q;
    logic [7:0] read_data;
    logic       nmi_request;
    logic       vblank;

    vupt_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tuser),
        .i_reg_index  (s_axis_tdata[2:0]),
        .i_write_data (s_axis_tdata[10:3]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s1_take    (s1_take),
        .o_s1         (s1),
        .o_mem        (mem)
    );

    vupt_ram #(.WIDTH(8), .DEPTH(PAT_DEPTH)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we_pat),
        .i_waddr (mem.a_pat),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.a_pat),
        .o_rdata (pat_q)
    );

    vupt_ram #(.WIDTH(8), .DEPTH(NT_DEPTH)) u_nt_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we_nt),
        .i_waddr (mem.a_nt),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.a_nt),
        .o_rdata (nt_q)
    );

    vupt_ram #(.WIDTH(8), .DEPTH(PAL_DEPTH)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we_pal),
        .i_waddr (mem.a_pal),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.a_pal),
        .o_rdata (pal_q)
    );

    vupt_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1),
        .i_pat_q     (pat_q),
        .i_nt_q      (nt_q),
        .i_pal_q     (pal_q),
        .i_ready     (m_axis_tready),
        .o_take      (s1_take),
        .o_valid     (m_axis_tvalid),
        .o_read_data (read_data),
        .o_nmi       (nmi_request),
        .o_vblank    (vblank)
    );

    assign m_axis_tdata = {6'd0, vblank, nmi_request, read_data};

endmodule

`default_nettype wire

@@ tb/tb_video_unit_register_port_and_timing.sv @@
// testbench for the video unit register port and dot timing block
// drives random and directed requests, predicts each result, depends on vupt_pkg and the rtl
`timescale 1ns / 1ps

module tb_video_unit_register_port_and_timing;
    import vupt_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT    = 3000000;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi;
        logic       vblank;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [2:0] reg_index, [10:3] write_data
    logic [1:0]  s_axis_tuser;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] read_data, [8] nmi_request, [9] vblank
    logic        i_cfg_we;
    logic        i_cfg_wdata;

    video_unit_register_port_and_timing DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predicted state of the video unit
    logic [7:0]  pat_mem [PAT_DEPTH];
    logic [7:0]  nt_mem [NT_DEPTH];
    logic [7:0]  pal_mem [PAL_DEPTH];
    logic [7:0]  ctrl_reg;
    logic [7:0]  status_reg;
    logic [14:0] v_addr;
    logic [14:0] t_addr;
    logic        write_toggle;
    logic [7:0]  rd_buffer;
    logic [8:0]  scan_dot;
    logic [8:0]  scan_line;
    logic        nmi_pending;
    logic        mirror_mode;

    t_reply reply_q[$];
    int     fail_count;
    int     requests_sent;
    int     cycle_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     tx_calm;
    int     rx_calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side stalls, with occasional stretches of steady acceptance
    always @(posedge i_clk) begin
        if (rx_calm > 0) begin
            rx_calm <= rx_calm - 1;
            m_axis_tready <= 1'b1;
        end else begin
            if ($urandom_range(99) < 2) rx_calm <= $urandom_range(120, 20);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [10:0] nt_slot(input logic [13:0] a);
        logic tbl;
        tbl = mirror_mode ? a[10] : a[11];
        return {tbl, a[9:0]};
    endfunction

    function automatic logic [4:0] pal_slot(input logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if (p[1:0] == 2'b00) p[4] = 1'b0;
        return p;
    endfunction

    function automatic t_reply video_unit_step(input logic [1:0] f, input logic [2:0] idx,
                                               input logic [7:0] d);
        t_reply      r;
        logic [13:0] a;
        logic [7:0]  v;
        logic [4:0]  y;
        logic        visible;
        r.read_data = 8'h00;
        a = v_addr[13:0];
        case (f)
            FUNC_WRITE: begin
                case (idx)
                    REG_CTRL: begin
                        ctrl_reg = d;
                        t_addr[11:10] = d[1:0];
                    end
                    REG_SCROLL: begin
                        if (!write_toggle) begin
                            t_addr[4:0] = d[7:3];
                        end else begin
                            t_addr[14:12] = d[2:0];
                            t_addr[9:5] = d[7:3];
                        end
                        write_toggle = ~write_toggle;
                    end
                    REG_ADDR: begin
                        if (!write_toggle) begin
                            t_addr[14:8] = {1'b0, d[5:0]};
                        end else begin
                            t_addr[7:0] = d;
                            v_addr = t_addr;
                        end
                        write_toggle = ~write_toggle;
                    end
                    REG_DATA: begin
                        if (a < 14'h2000) pat_mem[a[12:0]] = d;
                        else if (a < 14'h3F00) nt_mem[nt_slot(a)] = d;
                        else pal_mem[pal_slot(a)] = d;
                        v_addr = v_addr + (ctrl_reg[2] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            end
            FUNC_READ: begin
                if (idx == REG_STATUS) begin
                    r.read_data = status_reg;
                    status_reg[7] = 1'b0;
                    write_toggle = 1'b0;
                    nmi_pending = 1'b0;
                end else if (idx == REG_DATA) begin
                    if (a < 14'h2000) v = pat_mem[a[12:0]];
                    else if (a < 14'h3F00) v = nt_mem[nt_slot(a)];
                    else v = pal_mem[pal_slot(a)];
                    // palette reads bypass the buffer delay
                    r.read_data = (a < 14'h3F00) ? rd_buffer : v;
                    rd_buffer = v;
                    v_addr = v_addr + (ctrl_reg[2] ? 15'd32 : 15'd1);
                end
            end
            FUNC_TICK: begin
                scan_dot = scan_dot + 9'd1;
                visible = (scan_line < VISIBLE_LINES);
                if (visible && scan_dot <= LAST_FETCH_DOT && scan_dot[2:0] == 3'd0) begin
                    if (v_addr[4:0] == 5'd31) begin
                        v_addr[4:0] = 5'd0;
                        v_addr[10] = ~v_addr[10];
                    end else begin
                        v_addr[4:0] = v_addr[4:0] + 5'd1;
                    end
                end
                if (visible && scan_dot == LAST_FETCH_DOT) begin
                    if (v_addr[14:12] != 3'd7) begin
                        v_addr[14:12] = v_addr[14:12] + 3'd1;
                    end else begin
                        v_addr[14:12] = 3'd0;
                        y = v_addr[9:5];
                        if (y == 5'd29) begin
                            y = 5'd0;
                            v_addr[11] = ~v_addr[11];
                        end else if (y == 5'd31) begin
                            y = 5'd0;
                        end else begin
                            y = y + 5'd1;
                        end
                        v_addr[9:5] = y;
                    end
                end
                nmi_pending = 1'b0;
                if (scan_line == VBLANK_LINE && scan_dot == 9'd1) begin
                    status_reg[7] = 1'b1;
                    nmi_pending = ctrl_reg[7];
                end
                if (scan_line == PRERENDER_LINE && scan_dot == 9'd1) status_reg[7] = 1'b0;
                if (scan_dot >= DOTS_PER_LINE) begin
                    scan_dot = 9'd0;
                    scan_line = (scan_line == 9'd261) ? 9'd0 : scan_line + 9'd1;
                end
            end
            default: ;
        endcase
        r.nmi = nmi_pending;
        r.vblank = status_reg[7];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned expv,
                                   input int unsigned gotv);
        if (fail_count < 100)
            $display("mismatch %s: expected %0h got %0h at %0t", what, expv, gotv, $realtime);
        fail_count++;
    endtask

    // values at the falling edge hold until the next rising edge, so the handshake is known here
    always @(negedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reply_q.size() == 0) begin
                report_mismatch("result with no request pending", 0, 32'(m_axis_tdata));
            end else begin
                want = reply_q.pop_front();
                if (m_axis_tdata[7:0] !== want.read_data)
                    report_mismatch("read_data", 32'(want.read_data), 32'(m_axis_tdata[7:0]));
                if (m_axis_tdata[8] !== want.nmi)
                    report_mismatch("nmi_request", 32'(want.nmi), 32'(m_axis_tdata[8]));
                if (m_axis_tdata[9] !== want.vblank)
                    report_mismatch("vblank", 32'(want.vblank), 32'(m_axis_tdata[9]));
            end
        end
    end

    task automatic send_request(input logic [1:0] f, input logic [2:0] idx, input logic [7:0] d);
        logic took;
        if (tx_calm > 0) tx_calm--;
        else if ($urandom_range(99) < 2) tx_calm = $urandom_range(120, 20);
        if (tx_calm == 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b00000, d, idx};
        s_axis_tuser <= f;
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        reply_q.push_back(video_unit_step(f, idx, d));
        requests_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
        send_request(FUNC_WRITE, idx, d);
    endtask

    task automatic read_reg(input logic [2:0] idx);
        send_request(FUNC_READ, idx, 8'($urandom_range(255)));
    endtask

    task automatic send_tick;
        send_request(FUNC_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)));
    endtask

    task automatic wait_for_replies;
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mirroring(input logic m);
        wait_for_replies();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror_mode = m;
    endtask

    // one short cpu-like access sequence; ctrl writes only when allowed
    task automatic send_access_burst(input logic allow_ctrl);
        int         k;
        int         n;
        logic [7:0] hi;
        k = $urandom_range(99);
        if (k < 45) begin
            if ($urandom_range(1)) read_reg(REG_STATUS);
            hi = 8'($urandom_range(255));
            case ($urandom_range(3))
                0: hi[5:0] = 6'h3F;
                1: hi[5:4] = 2'b10;
                2: hi[5:4] = 2'b11;
                default: ;
            endcase
            write_reg(REG_ADDR, hi);
            write_reg(REG_ADDR, 8'($urandom_range(255)));
            n = $urandom_range(8, 1);
            repeat (n) begin
                if ($urandom_range(1)) write_reg(REG_DATA, 8'($urandom_range(255)));
                else read_reg(REG_DATA);
            end
        end else if (k < 65) begin
            write_reg(REG_SCROLL, 8'($urandom_range(255)));
            write_reg(REG_SCROLL, 8'($urandom_range(255)));
        end else if (k < 80) begin
            read_reg(REG_STATUS);
        end else if (k < 90 && allow_ctrl) begin
            write_reg(REG_CTRL, 8'($urandom_range(255)));
        end else if ($urandom_range(1)) begin
            write_reg(REG_DATA, 8'($urandom_range(255)));
        end else begin
            read_reg(REG_DATA);
        end
    endtask

    task automatic test_register_basics;
        // status starts with vblank set; the first read clears it
        read_reg(REG_STATUS);
        read_reg(REG_STATUS);
        write_reg(REG_MASK, 8'hFF);
        write_reg(REG_STATUS, 8'hFF);
        write_reg(REG_OAM_ADDR, 8'hFF);
        write_reg(REG_OAM_DATA, 8'hFF);
        read_reg(REG_CTRL);
        read_reg(REG_MASK);
        read_reg(REG_OAM_ADDR);
        read_reg(REG_OAM_DATA);
        read_reg(REG_SCROLL);
        read_reg(REG_ADDR);
        send_request(FUNC_UNUSED, REG_DATA, 8'hFF);
        write_reg(REG_CTRL, 8'h00);
        // palette entry 0x10 aliases 0x00, read back without delay
        write_reg(REG_ADDR, 8'h3F);
        write_reg(REG_ADDR, 8'h10);
        write_reg(REG_DATA, 8'hAB);
        write_reg(REG_ADDR, 8'h3F);
        write_reg(REG_ADDR, 8'h00);
        read_reg(REG_DATA);
        // nametable 0 and 1 share under horizontal mirroring, reads lag by one
        write_reg(REG_ADDR, 8'h20);
        write_reg(REG_ADDR, 8'h00);
        write_reg(REG_DATA, 8'h5A);
        write_reg(REG_ADDR, 8'h24);
        write_reg(REG_ADDR, 8'h00);
        read_reg(REG_DATA);
        read_reg(REG_DATA);
        write_reg(REG_SCROLL, 8'hFF);
        write_reg(REG_SCROLL, 8'h00);
        write_reg(REG_CTRL, 8'hFF);
    endtask

    // step by 32 from 0x3fe0 on past the point where the 15-bit address rolls over to zero
    task automatic test_address_wrap;
        int i;
        write_reg(REG_CTRL, 8'h04);
        read_reg(REG_STATUS);
        write_reg(REG_ADDR, 8'h3F);
        write_reg(REG_ADDR, 8'hE0);
        for (i = 0; i < 530; i++) begin
            if ($urandom_range(1)) write_reg(REG_DATA, 8'($urandom_range(255)));
            else read_reg(REG_DATA);
        end
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        int k;
        int n;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            k = $urandom_range(99);
            if (k < 45) begin
                send_access_burst(1'b1);
            end else if (k < 80) begin
                n = $urandom_range(60, 1);
                repeat (n) send_tick();
            end else begin
                send_request(2'($urandom_range(3)), 3'($urandom_range(7)),
                             8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 16'h0000;
        s_axis_tuser <= 2'd0;
        m_axis_tready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_rst_n <= 1'b0;
        for (int i = 0; i < PAT_DEPTH; i++) pat_mem[i] = 8'h00;
        for (int i = 0; i < NT_DEPTH; i++) nt_mem[i] = 8'h00;
        for (int i = 0; i < PAL_DEPTH; i++) pal_mem[i] = 8'h00;
        ctrl_reg = 8'h00;
        status_reg = 8'hA0;
        v_addr = 15'd0;
        t_addr = 15'd0;
        write_toggle = 1'b0;
        rd_buffer = 8'h00;
        scan_dot = 9'd0;
        scan_line = 9'd0;
        nmi_pending = 1'b0;
        mirror_mode = 1'b0;
        fail_count = 0;
        requests_sent = 0;
        cycle_count = 0;
        tx_calm = 0;
        rx_calm = 0;
        send_idle_pct = 30;
        recv_idle_pct = 47;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_mirroring(1'b0);
        test_register_basics();
        test_address_wrap();
        test_random_traffic(150);

        send_idle_pct = 47;
        recv_idle_pct = 30;
        set_mirroring(1'b1);
        test_random_traffic(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_mirroring(1'b0);
        test_random_traffic(75);
        set_mirroring(1'b1);
        test_random_traffic(75);

        wait_for_replies();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
